@@ hdl/hpc_pkg.sv @@
// Package: widths, register indexes, constants, controller states and command structs.
package hpc_pkg;

  localparam int unsigned GainW    = 24;
  localparam int unsigned DataW    = 32;
  localparam int unsigned YawW     = 19;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 24;
  localparam int unsigned CordicStepsDefault = 16;
  localparam int unsigned AtanEntries = 24;
  localparam int unsigned XyW      = 40;   // CORDIC x/y working width
  localparam int unsigned ZW       = 34;   // CORDIC angle width, Q2.30 plus headroom

  localparam logic [GainW-1:0] GainReset = 24'd32768;
  localparam logic signed [ZW-1:0] HalfPiQ30 = 34'sd1686629713;
  localparam logic [26:0] RotScaleQ30 = 27'd66466144;

  typedef enum logic [CfgIdxW-1:0] {
    REG_POS_GAIN = 2'd0,
    REG_VEL_P    = 2'd1,
    REG_VEL_I    = 2'd2,
    REG_VEL_D    = 2'd3
  } reg_idx_e;

  function automatic logic [31:0] atan_q30(input logic [4:0] idx);
    logic [31:0] r;
    case (idx)
      5'd0: r = 32'd843314856;
      5'd1: r = 32'd497837829;
      5'd2: r = 32'd263043836;
      5'd3: r = 32'd133525158;
      5'd4: r = 32'd67021686;
      5'd5: r = 32'd33543515;
      5'd6: r = 32'd16775850;
      5'd7: r = 32'd8388437;
      5'd8: r = 32'd4194282;
      5'd9: r = 32'd2097149;
      5'd10: r = 32'd1048575;
      5'd11: r = 32'd524287;
      5'd12: r = 32'd262143;
      5'd13: r = 32'd131071;
      5'd14: r = 32'd65535;
      5'd15: r = 32'd32767;
      5'd16: r = 32'd16383;
      5'd17: r = 32'd8191;
      5'd18: r = 32'd4095;
      5'd19: r = 32'd2047;
      5'd20: r = 32'd1023;
      5'd21: r = 32'd511;
      5'd22: r = 32'd255;
      5'd23: r = 32'd127;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

  function automatic logic signed [DataW-1:0] sat32(input logic signed [71:0] v);
    logic signed [DataW-1:0] r;
    if (v > 72'sd2147483647) r = 32'sh7fffffff;
    else if (v < -72'sd2147483648) r = 32'sh80000000;
    else r = v[DataW-1:0];
    return r;
  endfunction

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_POS_MUL,   // ep * position_gain
    ST_EV,        // dv, ev, integral update
    ST_P_MUL,
    ST_I_MUL,
    ST_D_MUL,
    ST_ACC,       // sum, sat, store axis result
    ST_ROT_PRE,
    ST_CORDIC,
    ST_PITCH_MUL,
    ST_ROLL_MUL,
    ST_OUT
  } state_e;

  typedef enum logic [2:0] {
    MUL_POS,
    MUL_P,
    MUL_I,
    MUL_D,
    MUL_PITCH,
    MUL_ROLL
  } mul_sel_e;

  typedef struct packed {
    logic     load;       // capture input request
    logic     mul_en;
    mul_sel_e mul_sel;
    logic     ev_en;
    logic     acc_en;
    logic     axis;       // 0: x, 1: y
    logic     rot_pre;
    logic     cordic_en;
    logic     out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic cordic_last;
  } dp_sts_t;

endpackage

@@ hdl/hpc_if.sv @@
// Valid/ready channel interfaces for input requests, results and register writes.
interface hpc_in_if;
  import hpc_pkg::*;
  logic valid;
  logic ready;
  logic signed [DataW-1:0] target_x;
  logic signed [DataW-1:0] target_y;
  logic signed [DataW-1:0] pos_x;
  logic signed [DataW-1:0] pos_y;
  logic signed [DataW-1:0] vel_x;
  logic signed [DataW-1:0] vel_y;
  logic signed [YawW-1:0]  yaw_angle;
  modport source (output valid, target_x, target_y, pos_x, pos_y, vel_x, vel_y, yaw_angle,
                  input ready);
  modport sink (input valid, target_x, target_y, pos_x, pos_y, vel_x, vel_y, yaw_angle,
                output ready);
endinterface

interface hpc_out_if;
  import hpc_pkg::*;
  logic valid;
  logic ready;
  logic signed [DataW-1:0] roll_target;
  logic signed [DataW-1:0] pitch_target;
  modport source (output valid, roll_target, pitch_target, input ready);
  modport sink (input valid, roll_target, pitch_target, output ready);
endinterface

interface hpc_cfg_if;
  import hpc_pkg::*;
  logic valid;
  logic ready;
  logic [CfgIdxW:0]    index;
  logic [CfgDataW-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ hdl/hpc_datapath.sv @@
// Datapath: gain registers, axis state, shared multiplier, CORDIC and output register.
module hpc_datapath
  import hpc_pkg::*;
#(
  parameter int unsigned CordicSteps = CordicStepsDefault
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  dp_cmd_t                 cmd_i,
  output dp_sts_t                 sts_o,
  input  logic                    cfg_we_i,
  input  logic [CfgIdxW:0]        cfg_idx_i,
  input  logic [CfgDataW-1:0]     cfg_data_i,
  input  logic signed [DataW-1:0] target_x_i,
  input  logic signed [DataW-1:0] target_y_i,
  input  logic signed [DataW-1:0] pos_x_i,
  input  logic signed [DataW-1:0] pos_y_i,
  input  logic signed [DataW-1:0] vel_x_i,
  input  logic signed [DataW-1:0] vel_y_i,
  input  logic signed [YawW-1:0]  yaw_angle_i,
  output logic signed [DataW-1:0] roll_target_o,
  output logic signed [DataW-1:0] pitch_target_o
);

  localparam int unsigned StepW = $clog2(CordicSteps);

  logic [GainW-1:0] pos_gain_q, vp_gain_q, vi_gain_q, vd_gain_q;
  logic signed [DataW-1:0] integ_q [2];
  logic signed [DataW-1:0] prev_q [2];

  logic signed [DataW:0]   ep_q [2];
  logic signed [DataW-1:0] vel_q [2];
  logic signed [YawW-1:0]  yaw_q;

  logic signed [DataW-1:0] ev_q;
  logic signed [DataW:0]   diff_q;
  logic signed [71:0]      prod_q;
  logic signed [71:0]      sum_q;
  logic signed [DataW-1:0] acc_q [2];

  logic signed [XyW-1:0] x_q, y_q;
  logic signed [ZW-1:0]  z_q;
  logic [StepW-1:0]      step_q;
  logic signed [DataW-1:0] pitch_q;

  logic signed [DataW-1:0] dv_d, ev_d, integ_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_gain_q <= GainReset;
      vp_gain_q  <= GainReset;
      vi_gain_q  <= GainReset;
      vd_gain_q  <= GainReset;
      integ_q[0] <= '0;
      integ_q[1] <= '0;
      prev_q[0]  <= '0;
      prev_q[1]  <= '0;
    end else begin
      if (cfg_we_i && cfg_idx_i[CfgIdxW] == 1'b0) begin
        case (reg_idx_e'(cfg_idx_i[CfgIdxW-1:0]))
          REG_POS_GAIN: pos_gain_q <= cfg_data_i;
          REG_VEL_P:    vp_gain_q  <= cfg_data_i;
          REG_VEL_I:    vi_gain_q  <= cfg_data_i;
          REG_VEL_D:    vd_gain_q  <= cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.ev_en) begin
        integ_q[cmd_i.axis] <= integ_d;
        prev_q[cmd_i.axis]  <= ev_d;
      end
    end
  end

  // ev / integral for the current axis, from the registered position product
  always_comb begin
    dv_d    = sat32(prod_q >>> 16);
    ev_d    = sat32(72'(dv_d) - 72'(vel_q[cmd_i.axis]));
    integ_d = sat32(72'(integ_q[cmd_i.axis]) + 72'(ev_d));
  end

  // shared multiplier: one operand pair per command, registered product
  logic signed [DataW+1:0] mul_a;
  logic signed [26:0]      mul_b;
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd_i.mul_sel)
      MUL_POS:   begin mul_a = 34'(ep_q[cmd_i.axis]); mul_b = {3'b0, pos_gain_q}; end
      MUL_P:     begin mul_a = 34'(ev_q);             mul_b = {3'b0, vp_gain_q};  end
      MUL_I:     begin mul_a = 34'(integ_q[cmd_i.axis]); mul_b = {3'b0, vi_gain_q}; end
      MUL_D:     begin mul_a = 34'(diff_q);           mul_b = {3'b0, vd_gain_q};  end
      MUL_PITCH: begin mul_a = 34'(x_q);              mul_b = RotScaleQ30;        end
      MUL_ROLL:  begin mul_a = 34'(-y_q);             mul_b = RotScaleQ30;        end
      default: ;
    endcase
  end

  // CORDIC x/y fit in 34 bits: |acc| < 2^31, gain < 1.65
  logic signed [XyW-1:0] xs, ys, x_n, y_n;
  logic signed [ZW-1:0]  z_n, at;
  always_comb begin
    xs = x_q >>> step_q;
    ys = y_q >>> step_q;
    at = ZW'(atan_q30(5'(step_q)));
    if (!z_q[ZW-1]) begin
      x_n = x_q - ys; y_n = y_q + xs; z_n = z_q - at;
    end else begin
      x_n = x_q + ys; y_n = y_q - xs; z_n = z_q + at;
    end
  end
  assign sts_o.cordic_last = (step_q == StepW'(CordicSteps - 1));

  logic signed [ZW-1:0] z0;
  assign z0 = -(ZW'(yaw_q) <<< 14);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      ep_q[0]  <= 33'(target_x_i) - 33'(pos_x_i);
      ep_q[1]  <= 33'(target_y_i) - 33'(pos_y_i);
      vel_q[0] <= vel_x_i;
      vel_q[1] <= vel_y_i;
      yaw_q    <= yaw_angle_i;
    end
    if (cmd_i.mul_en) prod_q <= 72'(mul_a) * 72'(mul_b);
    if (cmd_i.ev_en) begin
      ev_q   <= ev_d;
      diff_q <= 33'(ev_d) - 33'(prev_q[cmd_i.axis]);
      sum_q  <= '0;
    end
    if (cmd_i.mul_en && (cmd_i.mul_sel == MUL_I || cmd_i.mul_sel == MUL_D))
      sum_q <= sum_q + prod_q;
    if (cmd_i.acc_en) acc_q[cmd_i.axis] <= sat32((sum_q + prod_q) >>> 16);
    if (cmd_i.rot_pre) begin
      step_q <= '0;
      if (z0 > HalfPiQ30) begin
        x_q <= -XyW'(acc_q[1]); y_q <= XyW'(acc_q[0]); z_q <= z0 - HalfPiQ30;
      end else if (z0 < -HalfPiQ30) begin
        x_q <= XyW'(acc_q[1]); y_q <= -XyW'(acc_q[0]); z_q <= z0 + HalfPiQ30;
      end else begin
        x_q <= XyW'(acc_q[0]); y_q <= XyW'(acc_q[1]); z_q <= z0;
      end
    end
    if (cmd_i.cordic_en) begin
      x_q <= x_n; y_q <= y_n; z_q <= z_n;
      step_q <= step_q + StepW'(1);
    end
    if (cmd_i.mul_en && cmd_i.mul_sel == MUL_ROLL) pitch_q <= sat32(prod_q >>> 30);
    if (cmd_i.out_load) begin
      pitch_target_o <= pitch_q;
      roll_target_o  <= sat32(prod_q >>> 30);
    end
  end

endmodule

@@ hdl/hpc_ctrl.sv @@
// Controller: sequences both axes, the CORDIC and the output handshake.
module hpc_ctrl
  import hpc_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output dp_cmd_t cmd_o,
  input  dp_sts_t sts_i
);

  state_e state_q, state_d;
  logic axis_q, axis_d;
  logic ovalid_q, ovalid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      axis_q   <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      axis_q   <= axis_d;
      ovalid_q <= ovalid_d;
    end
  end

  assign out_valid_o = ovalid_q;

  always_comb begin
    state_d  = state_q;
    axis_d   = axis_q;
    ovalid_d = ovalid_q && !out_ready_i;
    cmd_o    = '0;
    cmd_o.axis = axis_q;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          axis_d  = 1'b0;
          state_d = ST_POS_MUL;
        end
      end
      ST_POS_MUL: begin
        cmd_o.mul_en = 1'b1; cmd_o.mul_sel = MUL_POS; state_d = ST_EV;
      end
      ST_EV:    begin cmd_o.ev_en = 1'b1; state_d = ST_P_MUL; end
      ST_P_MUL: begin cmd_o.mul_en = 1'b1; cmd_o.mul_sel = MUL_P; state_d = ST_I_MUL; end
      ST_I_MUL: begin cmd_o.mul_en = 1'b1; cmd_o.mul_sel = MUL_I; state_d = ST_D_MUL; end
      ST_D_MUL: begin cmd_o.mul_en = 1'b1; cmd_o.mul_sel = MUL_D; state_d = ST_ACC; end
      ST_ACC: begin
        cmd_o.acc_en = 1'b1;
        if (axis_q) state_d = ST_ROT_PRE;
        else begin
          axis_d  = 1'b1;
          state_d = ST_POS_MUL;
        end
      end
      ST_ROT_PRE: begin cmd_o.rot_pre = 1'b1; state_d = ST_CORDIC; end
      ST_CORDIC: begin
        cmd_o.cordic_en = 1'b1;
        if (sts_i.cordic_last) state_d = ST_PITCH_MUL;
      end
      ST_PITCH_MUL: begin
        cmd_o.mul_en = 1'b1; cmd_o.mul_sel = MUL_PITCH; state_d = ST_ROLL_MUL;
      end
      ST_ROLL_MUL: begin
        // pitch product is taken from the register while roll is multiplied
        cmd_o.mul_en = 1'b1; cmd_o.mul_sel = MUL_ROLL; state_d = ST_OUT;
      end
      ST_OUT: begin
        if (!ovalid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          ovalid_d = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

@@ hdl/horizontal_position_controller.sv @@
// Top level: cascaded position/velocity PID with yaw rotation to roll and pitch targets.
//   channel  direction  payload
//   in_if    sink       target_x/y, pos_x/y, vel_x/y, yaw_angle
//   out_if   source     roll_target, pitch_target
//   cfg_if   sink       index, data (gains 0..3)
// A request runs through two axis passes on the shared multiplier (four products per axis pass)
// and then through the CORDIC iterations.
// The result sits in an output register; the next request is taken while it waits.
// Reset clears gains to 0.5 and the integral and previous error of both axes.
// Register writes are always taken.
module horizontal_position_controller
  import hpc_pkg::*;
#(
  parameter int unsigned CordicSteps = CordicStepsDefault
) (
  input  logic clk_i,
  input  logic rst_ni,
  hpc_in_if.sink    in_if,
  hpc_out_if.source out_if,
  hpc_cfg_if.sink   cfg_if
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  assign cfg_if.ready = 1'b1;

  hpc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_if.valid),
    .in_ready_o  (in_if.ready),
    .out_valid_o (out_if.valid),
    .out_ready_i (out_if.ready),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  hpc_datapath #(.CordicSteps(CordicSteps)) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .cfg_we_i       (cfg_if.valid),
    .cfg_idx_i      (cfg_if.index),
    .cfg_data_i     (cfg_if.data),
    .target_x_i     (in_if.target_x),
    .target_y_i     (in_if.target_y),
    .pos_x_i        (in_if.pos_x),
    .pos_y_i        (in_if.pos_y),
    .vel_x_i        (in_if.vel_x),
    .vel_y_i        (in_if.vel_y),
    .yaw_angle_i    (in_if.yaw_angle),
    .roll_target_o  (out_if.roll_target),
    .pitch_target_o (out_if.pitch_target)
  );

endmodule

@@ test/tb_pkg.sv @@
// Testbench package: request and result record types shared by the driver, predictor and monitor.
package tb_pkg;
  import hpc_pkg::*;

  typedef struct packed {
    logic signed [DataW-1:0] target_x;
    logic signed [DataW-1:0] target_y;
    logic signed [DataW-1:0] pos_x;
    logic signed [DataW-1:0] pos_y;
    logic signed [DataW-1:0] vel_x;
    logic signed [DataW-1:0] vel_y;
    logic signed [YawW-1:0]  yaw_angle;
  } tick_t;

  typedef struct packed {
    logic signed [DataW-1:0] roll_target;
    logic signed [DataW-1:0] pitch_target;
  } attitude_t;
endpackage

@@ test/tb.sv @@
// Testbench: random and directed control ticks checked against a bit-exact controller model.
module tb;
  import hpc_pkg::*;
  import tb_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Steps = CordicStepsDefault;
  localparam int unsigned Latency = 17 + Steps;
  localparam int unsigned WatchLimit = 4000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  hpc_in_if  in_if ();
  hpc_out_if out_if ();
  hpc_cfg_if cfg_if ();

  horizontal_position_controller #(.CordicSteps(Steps)) DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_if (in_if),
    .out_if(out_if),
    .cfg_if(cfg_if)
  );

  always #2 clk_i = ~clk_i;

  // controller model state
  logic [GainW-1:0] kpos, kvp, kvi, kvd;
  logic signed [31:0] integ_x, integ_y, prev_ev_x, prev_ev_y;

  tick_t     tick_q[$];
  attitude_t attitude_q[$];
  int        err_count = 0;
  bit        quiet = 1'b0;
  int        in_gap = 0, out_gap = 0;
  int        watch = 0;
  bit        finishing = 1'b0;

  function automatic logic signed [71:0] floor_sh(input logic signed [71:0] v, input int n);
    return v >>> n;
  endfunction

  function automatic logic signed [31:0] clamp32(input logic signed [71:0] v);
    if (v > 72'sd2147483647) return 32'sh7fffffff;
    if (v < -72'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic logic signed [31:0] axis_accel(input logic signed [31:0] tgt,
      input logic signed [31:0] pos, input logic signed [31:0] vel,
      inout logic signed [31:0] integ, inout logic signed [31:0] prev);
    logic signed [71:0] ep, dv, ev, diff, sum;
    ep = 72'(tgt) - 72'(pos);
    dv = 72'(clamp32(floor_sh(ep * $signed({48'd0, kpos}), 16)));
    ev = 72'(clamp32(dv - 72'(vel)));
    integ = clamp32(72'(integ) + ev);
    diff = ev - 72'(prev);
    sum = ev * $signed({48'd0, kvp}) + 72'(integ) * $signed({48'd0, kvi})
        + diff * $signed({48'd0, kvd});
    prev = ev[31:0];
    return clamp32(floor_sh(sum, 16));
  endfunction

  function automatic attitude_t attitude_of(input tick_t t);
    logic signed [71:0] x, y, z, xs, ys, tmp;
    attitude_t r;
    x = 72'(axis_accel(t.target_x, t.pos_x, t.vel_x, integ_x, prev_ev_x));
    y = 72'(axis_accel(t.target_y, t.pos_y, t.vel_y, integ_y, prev_ev_y));
    z = -(72'(t.yaw_angle) * 72'sd16384);
    if (z > 72'(HalfPiQ30)) begin
      tmp = x; x = -y; y = tmp; z = z - 72'(HalfPiQ30);
    end else if (z < -72'(HalfPiQ30)) begin
      tmp = x; x = y; y = -tmp; z = z + 72'(HalfPiQ30);
    end
    for (int i = 0; i < Steps && i < AtanEntries; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x = x - ys; y = y + xs; z = z - 72'(atan_q30(5'(i)));
      end else begin
        x = x + ys; y = y - xs; z = z + 72'(atan_q30(5'(i)));
      end
    end
    r.roll_target  = clamp32(floor_sh(-y * $signed(72'(RotScaleQ30)), 30));
    r.pitch_target = clamp32(floor_sh(x * $signed(72'(RotScaleQ30)), 30));
    return r;
  endfunction

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    err_count++;
  endtask

  // input driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
      in_gap = 0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        attitude_q.push_back(attitude_of(tick_q.pop_front()));
      end
      if (!(in_if.valid && !in_if.ready)) begin
        if (in_gap > 0) begin
          in_gap--;
          in_if.valid <= 1'b0;
        end else if (!quiet && $urandom_range(0, 15) == 0) begin
          in_gap = $urandom_range(1, 13) - 1;
          in_if.valid <= 1'b0;
        end else if (tick_q.size() > 0 && !finishing) begin
          in_if.valid     <= 1'b1;
          in_if.target_x  <= tick_q[0].target_x;
          in_if.target_y  <= tick_q[0].target_y;
          in_if.pos_x     <= tick_q[0].pos_x;
          in_if.pos_y     <= tick_q[0].pos_y;
          in_if.vel_x     <= tick_q[0].vel_x;
          in_if.vel_y     <= tick_q[0].vel_y;
          in_if.yaw_angle <= tick_q[0].yaw_angle;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk_i or negedge rst_ni) begin
    attitude_t want;
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      out_gap = 0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (attitude_q.size() == 0) begin
          report("unexpected", out_if.roll_target, 32'd0);
        end else begin
          want = attitude_q.pop_front();
          if (out_if.roll_target !== want.roll_target)
            report("roll_target", out_if.roll_target, want.roll_target);
          if (out_if.pitch_target !== want.pitch_target)
            report("pitch_target", out_if.pitch_target, want.pitch_target);
        end
      end
      if (out_gap > 0) begin
        out_gap--;
        out_if.ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 15) == 0) begin
        out_gap = $urandom_range(1, 13) - 1;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // watchdog on cycles without any handshake on the input, output or register channel
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)
          || (cfg_if.valid && cfg_if.ready))
        watch <= 0;
      else
        watch <= watch + 1;
      if (watch >= WatchLimit) begin
        $display("tb: done, errors");
        $finish;
      end
    end
  end

  function automatic logic signed [31:0] rand_val(input int mode);
    case (mode)
      0: return $signed($urandom());
      1: return $signed($urandom_range(0, 32'h60000)) - 32'sh30000;
      2: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
      default: return $signed($urandom_range(0, 32'h2000000)) - 32'sh1000000;
    endcase
  endfunction

  function automatic tick_t rand_tick();
    tick_t t;
    int m;
    m = $urandom_range(0, 9);
    m = (m < 5) ? 1 : (m < 7) ? 3 : (m < 9) ? 0 : 2;
    t.target_x = rand_val(m);
    t.target_y = rand_val(m);
    t.pos_x = rand_val(m);
    t.pos_y = rand_val(m);
    t.vel_x = rand_val($urandom_range(0, 3));
    t.vel_y = rand_val($urandom_range(0, 3));
    if ($urandom_range(0, 9) == 0) t.yaw_angle = 19'($urandom());
    else t.yaw_angle = 19'($signed($urandom_range(0, 411774)) - 205887);
    return t;
  endfunction

  // writes one gain register and updates the model's copy of that gain
  task automatic write_gain(input reg_idx_e idx, input logic [GainW-1:0] val);
    @(posedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= {1'b0, idx};
    cfg_if.data  <= val;
    do @(posedge clk_i); while (!cfg_if.ready);
    case (idx)
      REG_POS_GAIN: kpos = val;
      REG_VEL_P:    kvp = val;
      REG_VEL_I:    kvi = val;
      default:      kvd = val;
    endcase
    cfg_if.valid <= 1'b0;
  endtask

  // stray index above the gain range: must be ignored
  task automatic write_stray(input logic [GainW-1:0] val);
    @(posedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= {1'b1, 2'($urandom())};
    cfg_if.data  <= val;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic drain();
    wait (tick_q.size() == 0 && attitude_q.size() == 0);
    repeat (Latency + 4) @(posedge clk_i);
  endtask

  task automatic run_phase(input int n);
    for (int i = 0; i < n; i++) tick_q.push_back(rand_tick());
    drain();
  endtask

  initial begin
    tick_t t;
    logic [GainW-1:0] g;
    in_if.valid = 1'b0;
    in_if.target_x = '0; in_if.target_y = '0; in_if.pos_x = '0;
    in_if.pos_y = '0; in_if.vel_x = '0; in_if.vel_y = '0; in_if.yaw_angle = '0;
    out_if.ready = 1'b0;
    cfg_if.valid = 1'b0; cfg_if.index = '0; cfg_if.data = '0;
    kpos = GainReset; kvp = GainReset; kvi = GainReset; kvd = GainReset;
    integ_x = 0; integ_y = 0; prev_ev_x = 0; prev_ev_y = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: field extremes, quadrant turns, out-of-range headings, then random ticks with x zeroed
    for (int i = 0; i < 20; i++) begin
      t.target_x = (i % 2) ? 32'sh7fffffff : 32'sh80000000;
      t.target_y = (i % 3 == 0) ? 32'sh7fffffff : 32'sh80000000;
      t.pos_x = -t.target_x; t.pos_y = (i % 4 < 2) ? t.target_y : -t.target_y;
      t.vel_x = (i % 5 == 0) ? 32'sh80000000 : 32'sh7fffffff;
      t.vel_y = (i % 2) ? 32'sh00010000 : -32'sh00010000;
      case (i % 8)
        0: t.yaw_angle = 19'sd205887;
        1: t.yaw_angle = -19'sd205887;
        2: t.yaw_angle = 19'sh3ffff;
        3: t.yaw_angle = 19'sh40000;
        4: t.yaw_angle = 19'sd102944;
        5: t.yaw_angle = -19'sd102944;
        6: t.yaw_angle = 19'sd0;
        default: t.yaw_angle = 19'sd102943;
      endcase
      if (i >= 12) begin
        t = rand_tick();
        t.target_x = 0; t.pos_x = 0; t.vel_x = 0;
      end
      tick_q.push_back(t);
    end
    drain();

    write_gain(REG_POS_GAIN, 24'hffffff);
    write_gain(REG_VEL_P, 24'hffffff);
    write_gain(REG_VEL_I, 24'hffffff);
    write_gain(REG_VEL_D, 24'hffffff);
    write_stray(24'h000001);
    run_phase(150);

    write_gain(REG_POS_GAIN, 24'd0);
    write_gain(REG_VEL_P, 24'd0);
    write_gain(REG_VEL_I, 24'd0);
    write_gain(REG_VEL_D, 24'd0);
    run_phase(50);

    for (int p = 0; p < 8; p++) begin
      for (int r = 0; r < 4; r++) begin
        g = ($urandom_range(0, 2) == 0) ? 24'($urandom()) : 24'($urandom_range(0, 24'h30000));
        write_gain(reg_idx_e'(r), g);
      end
      if (p == 3) write_stray(24'($urandom()));
      run_phase(140);
    end

    quiet = 1'b1;
    run_phase(210);
    finishing = 1'b1;
    if (err_count == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end
endmodule
